// File: rtl/gma_pkg.sv
// Package for the gated moving average block: sample and sum types,
// the sequencer state type and fixed widths.
// No dependencies; gma_div and the top level in rtl use it by scoped names.
`default_nettype none

package gma_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 24;
    localparam int FILL_OUT_W = 9;
    // Counter for the one-bit-per-cycle divider steps.
    localparam int STEP_W   = $clog2(SUM_W);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [SAMPLE_W+2:0] t_band;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// File: rtl/gma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the sample ring of the moving average.
`default_nettype none

module gma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/gma_div.sv
// Iterative signed divider: one quotient bit per cycle, quotient truncated
// toward zero. Depends on gma_pkg for the sum type and step counter width.
`default_nettype none

module gma_div #(
    parameter int DIV_W = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire gma_pkg::t_sum      i_dividend,
    input  wire logic [DIV_W-1:0]   i_divisor,
    output gma_pkg::t_sum           o_quotient,
    output logic                    o_done
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic                          r_neg, n_neg;
    logic [gma_pkg::SUM_W-1:0]     r_quo, n_quo;
    logic [DIV_W-1:0]              r_rem, n_rem;
    logic [gma_pkg::STEP_W-1:0]    r_cnt, n_cnt;
    logic [DIV_W:0]                w_shift;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_neg   = r_neg;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        w_shift = {r_rem, r_quo[gma_pkg::SUM_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_neg  = i_dividend[gma_pkg::SUM_W-1];
            n_quo  = i_dividend[gma_pkg::SUM_W-1] ? -i_dividend : i_dividend;
            n_rem  = '0;
            n_cnt  = '0;
        end else if (r_busy) begin
            // Restoring step on the magnitude: shift in the next dividend bit.
            if (w_shift >= {1'b0, i_divisor}) begin
                n_rem = DIV_W'(w_shift - {1'b0, i_divisor});
                n_quo = {r_quo[gma_pkg::SUM_W-2:0], 1'b1};
            end else begin
                n_rem = DIV_W'(w_shift);
                n_quo = {r_quo[gma_pkg::SUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == gma_pkg::STEP_W'(gma_pkg::SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_neg <= n_neg;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_quotient = r_neg ? -gma_pkg::t_sum'(r_quo) : gma_pkg::t_sum'(r_quo);
    assign o_done     = r_done;

endmodule

`default_nettype wire

// File: rtl/gated_moving_average_top.sv
// Top level of the gated moving average: sequencer, outlier band test,
// running sum and output register. Depends on gma_pkg, gma_ram and gma_div.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_stall    i_sample
//   out      from block o_out_valid / i_out_stall  o_accepted, o_average, o_fill_count
//
// An accepted item's result is offered after the band test, one divider step per quotient
// bit, storing the mean and loading the output; a rejected item skips the divider. The
// next item can be taken in the cycle in which the result is offered.
// Reset is synchronous and active low; the ring is not cleared, since an old slot value
// is used only once the window is full and every slot has been written.
// The input stalls while an item is in work, and a stalled output holds back the next result.
`default_nettype none

module gated_moving_average_top #(
    parameter int WINDOW = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire gma_pkg::t_sample  i_sample,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_accepted,
    output gma_pkg::t_sample       o_average,
    output logic [gma_pkg::FILL_OUT_W-1:0] o_fill_count
);

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);

    gma_pkg::t_state        r_state, n_state;
    gma_pkg::t_sample       r_sample, n_sample;
    gma_pkg::t_sample       r_mean, n_mean;
    gma_pkg::t_sum          r_sum, n_sum;
    logic [IDX_W-1:0]       r_widx, n_widx;
    logic [FILL_W-1:0]      r_fill, n_fill;
    logic                   r_ok, n_ok;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_acc, n_out_acc;
    gma_pkg::t_sample       r_out_avg, n_out_avg;
    logic [gma_pkg::FILL_OUT_W-1:0] r_out_fill, n_out_fill;

    logic                   w_ram_we;
    gma_pkg::t_sample       w_old;
    logic                   w_full;
    gma_pkg::t_band         w_s2, w_m2, w_mag, w_lo, w_hi;
    logic                   w_in_band;
    logic                   w_div_start;
    logic                   w_div_done;
    gma_pkg::t_sum          w_quotient;
    gma_pkg::t_sum          w_sum_upd;

    gma_ram #(
        .WIDTH(gma_pkg::SAMPLE_W),
        .DEPTH(WINDOW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(r_widx),
        .i_wdata(r_sample),
        .i_raddr(r_widx),
        .o_rdata(w_old)
    );

    // The divider starts from the updated sum in the same cycle as the update.
    gma_div #(
        .DIV_W(FILL_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_sum_upd),
        .i_divisor (r_fill),
        .o_quotient(w_quotient),
        .o_done    (w_div_done)
    );

    assign w_full = (r_fill == FILL_W'(WINDOW));

    // Band test on doubled values, so that half the mean's magnitude is exact.
    always_comb begin
        w_s2      = gma_pkg::t_band'(r_sample) <<< 1;
        w_m2      = gma_pkg::t_band'(r_mean) <<< 1;
        w_mag     = r_mean[gma_pkg::SAMPLE_W-1] ? -gma_pkg::t_band'(r_mean)
                                                 : gma_pkg::t_band'(r_mean);
        w_lo      = w_m2 - w_mag;
        w_hi      = w_m2 + w_mag;
        w_in_band = !((w_s2 < w_lo) || (w_s2 > w_hi));
    end

    // Until the window is full the slot being replaced was never written.
    assign w_sum_upd = r_sum + gma_pkg::t_sum'(r_sample)
                     - (w_full ? gma_pkg::t_sum'(w_old) : gma_pkg::t_sum'(0));

    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_mean      = r_mean;
        n_sum       = r_sum;
        n_widx      = r_widx;
        n_fill      = r_fill;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out_acc   = r_out_acc;
        n_out_avg   = r_out_avg;
        n_out_fill  = r_out_fill;
        w_ram_we    = 1'b0;
        w_div_start = 1'b0;
        o_in_stall  = 1'b1;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            gma_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_sample = i_sample;
                    n_state  = gma_pkg::S_CHECK;
                end
            end
            gma_pkg::S_CHECK: begin
                if (!w_full || w_in_band) begin
                    n_ok        = 1'b1;
                    n_sum       = w_sum_upd;
                    w_ram_we    = 1'b1;
                    n_widx      = (r_widx == IDX_W'(WINDOW - 1)) ? '0 : r_widx + 1'b1;
                    n_fill      = w_full ? r_fill : r_fill + 1'b1;
                    w_div_start = 1'b1;
                    n_state     = gma_pkg::S_DIV;
                end else begin
                    n_ok    = 1'b0;
                    n_state = gma_pkg::S_FINISH;
                end
            end
            gma_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_mean  = gma_pkg::t_sample'(w_quotient);
                    n_state = gma_pkg::S_FINISH;
                end
            end
            gma_pkg::S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_acc   = r_ok;
                    n_out_avg   = r_mean;
                    n_out_fill  = gma_pkg::FILL_OUT_W'(r_fill);
                    n_state     = gma_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gma_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gma_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean      <= '0;
            r_sum       <= '0;
            r_widx      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mean      <= n_mean;
            r_sum       <= n_sum;
            r_widx      <= n_widx;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_sample   <= n_sample;
        r_ok       <= n_ok;
        r_out_acc  <= n_out_acc;
        r_out_avg  <= n_out_avg;
        r_out_fill <= n_out_fill;
    end

    assign o_out_valid  = r_out_valid;
    assign o_accepted   = r_out_acc;
    assign o_average    = r_out_avg;
    assign o_fill_count = r_out_fill;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW))
        else $error("fill level beyond window size");

    a_idx_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != FILL_W'(WINDOW)) |-> (r_widx == IDX_W'(r_fill)))
        else $error("write index out of step with fill level while filling");

    a_reject_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |-> (o_fill_count == gma_pkg::FILL_OUT_W'(WINDOW)))
        else $error("item rejected before the window was full");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == gma_pkg::S_DIV))
        else $error("divider finished outside the divide phase");
`endif

endmodule

`default_nettype wire

// File: tb/gated_moving_average_checker.sv
// Checker for the gated moving average: watches both channels, predicts each
// result from its own copy of the window and compares it with what the block returns.
// Depends on gma_pkg for the sample type and the fill count width.
module gated_moving_average_checker #(
    parameter int WINDOW = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  gma_pkg::t_sample                i_sample,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic                            i_accepted,
    input  gma_pkg::t_sample                i_average,
    input  logic [gma_pkg::FILL_OUT_W-1:0]  i_fill_count,
    output int                              o_fail_count,
    output int                              o_pending,
    output gma_pkg::t_sample                o_mean
);
    timeunit 1ns;
    timeprecision 1ps;

    import gma_pkg::*;

    typedef struct {
        bit                     accepted;
        t_sample                average;
        logic [FILL_OUT_W-1:0]  fill_count;
    } t_filter_out;

    t_sample     window_ring [WINDOW];
    int          next_slot;
    int          held;
    int          ring_total;
    t_sample     mean_now;
    int          mismatches;
    t_filter_out queued_outputs [$];

    // Bounds are compared on doubled values, so half of the mean's magnitude is exact.
    function automatic bit near_mean(input int s, input int m);
        int mag;
        mag = (m < 0) ? -m : m;
        return !((2 * s < 2 * m - mag) || (2 * s > 2 * m + mag));
    endfunction

    function automatic t_filter_out filter_step(input t_sample s);
        t_filter_out r;
        bit          take;
        take = (held < WINDOW) || near_mean(int'(s), int'(mean_now));
        if (take) begin
            ring_total = ring_total + int'(s) - int'(window_ring[next_slot]);
            window_ring[next_slot] = s;
            next_slot = (next_slot + 1) % WINDOW;
            if (held < WINDOW) begin
                held++;
            end
            // Integer division truncates toward zero, as the block must.
            mean_now = t_sample'(ring_total / held);
        end
        r.accepted   = take;
        r.average    = mean_now;
        r.fill_count = FILL_OUT_W'(held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_filter_out want;
        if (!i_rst_n) begin
            foreach (window_ring[k]) begin
                window_ring[k] = '0;
            end
            next_slot  = 0;
            held       = 0;
            ring_total = 0;
            mean_now   = '0;
            mismatches = 0;
            queued_outputs.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (queued_outputs.size() == 0) begin
                    $error("result with no item waiting: accepted %0b, average %0d, fill_count %0d",
                           i_accepted, i_average, i_fill_count);
                    mismatches++;
                end else begin
                    want = queued_outputs.pop_front();
                    if (i_accepted !== want.accepted) begin
                        $error("accepted: expected %0b, got %0b", want.accepted, i_accepted);
                        mismatches++;
                    end
                    if (i_average !== want.average) begin
                        $error("average: expected %0d, got %0d", want.average, i_average);
                        mismatches++;
                    end
                    if (i_fill_count !== want.fill_count) begin
                        $error("fill_count: expected %0d, got %0d", want.fill_count,
                               i_fill_count);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                queued_outputs.push_back(filter_step(i_sample));
            end
        end
        o_pending    <= queued_outputs.size();
        o_mean       <= mean_now;
        o_fail_count <= mismatches;
    end

endmodule

// File: tb/gated_moving_average_top_test.sv
// Testbench top for the gated moving average: clock, reset, sample stimulus,
// random idling on both channels, watchdog and verdict.
// Depends on gma_pkg, the block under test and gated_moving_average_checker.
module gated_moving_average_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gma_pkg::*;

    localparam int WINDOW       = 8;
    localparam int RANDOM_ITEMS = 1280;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_sample                i_sample;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic                   o_accepted;
    t_sample                o_average;
    logic [FILL_OUT_W-1:0]  o_fill_count;

    int      chk_fail_count;
    int      chk_pending;
    t_sample chk_mean;
    int      quiet_cycles;
    bit      calm;

    gated_moving_average_top #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_accepted   (o_accepted),
        .o_average    (o_average),
        .o_fill_count (o_fill_count)
    );

    gated_moving_average_checker #(
        .WINDOW(WINDOW)
    ) filter_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_accepted   (o_accepted),
        .i_average    (o_average),
        .i_fill_count (o_fill_count),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending),
        .o_mean       (chk_mean)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones, none at all during calm stretches.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm) begin
            return 0;
        end
        if (r < 45) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_sample to_sample(input int v);
        if (v > 32767) begin
            return t_sample'(32767);
        end
        if (v < -32768) begin
            return t_sample'(-32768);
        end
        return t_sample'(v);
    endfunction

    // Smallest and largest samples that pass the outlier test around mean m.
    function automatic void band_edges(input int m, output int lo, output int hi);
        int mag;
        int lo2;
        int hi2;
        mag = (m < 0) ? -m : m;
        lo2 = 2 * m - mag;
        hi2 = 2 * m + mag;
        lo  = (lo2 >= 0) ? (lo2 + 1) / 2 : lo2 / 2;
        hi  = (hi2 >= 0) ? hi2 / 2 : (hi2 - 1) / 2;
    endfunction

    // The mean seen here may be one item old, so in-band picks keep a margin.
    function automatic t_sample pick_sample(input int m);
        int lo;
        int hi;
        int mag;
        int span;
        int r;
        int v;
        band_edges(m, lo, hi);
        mag  = (m < 0) ? -m : m;
        span = mag * 3 / 8;
        r    = $urandom_range(0, 99);
        if (r < 18) begin
            v = int'(t_sample'($urandom));
        end else if (r < 26) begin
            case ($urandom_range(0, 3))
                0: v = lo - 1;
                1: v = lo;
                2: v = hi;
                default: v = hi + 1;
            endcase
        end else if (mag < 64) begin
            // Push a small mean outward so the window does not settle near zero.
            v = (m >= 0) ? hi : lo;
        end else if (mag > 12000) begin
            v = (m >= 0) ? m - $urandom_range(0, span) : m + $urandom_range(0, span);
        end else begin
            v = m - span + $urandom_range(0, 2 * span);
        end
        return to_sample(v);
    endfunction

    task automatic push_sample(input t_sample s);
        int n;
        i_sample   <= s;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        n = gap_len();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Lets every outstanding result drain so the predicted mean is current.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
    endtask

    initial begin
        t_sample first_fill [WINDOW];
        int      lo;
        int      hi;
        first_fill = '{-32768, 32767, -1, 1, 16384, -16384, 255, -255};
        calm        = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_sample   <= '0;
        i_out_stall <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Filling the window: every item is taken, and the sum ends at -1 so the
        // mean truncates to zero with the ring still holding nonzero samples.
        foreach (first_fill[k]) begin
            push_sample(first_fill[k]);
        end
        // Zero mean with a full window: only a zero sample gets in.
        push_sample(t_sample'(1));
        push_sample(t_sample'(-1));
        push_sample(t_sample'(0));
        // Samples just outside and on the edges of the band.
        for (int k = 0; k < 3; k++) begin
            settle();
            band_edges(int'(chk_mean), lo, hi);
            push_sample(to_sample(lo - 1));
            push_sample(to_sample(lo));
            settle();
            band_edges(int'(chk_mean), lo, hi);
            push_sample(to_sample(hi + 1));
            push_sample(to_sample(hi));
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 100 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
            end
            push_sample(pick_sample(int'(chk_mean)));
        end
        calm = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk_fail_count == 0) begin
            $display("gated_moving_average_top_test passed");
        end else begin
            $display("gated_moving_average_top_test failed");
        end
        $finish;
    end

    initial begin
        int n;
        forever begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            n = gap_len();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("gated_moving_average_top_test failed");
            $finish;
        end
    end

    initial begin
        quiet_cycles = 0;
    end

endmodule

// File: sim.f
rtl/gma_pkg.sv
rtl/gma_ram.sv
rtl/gma_div.sv
rtl/gated_moving_average_top.sv
tb/gated_moving_average_checker.sv
tb/gated_moving_average_top_test.sv
